// ===== rtl/rgbseq_pkg.sv =====
`default_nettype none

package rgbseq_pkg;

	localparam int LEVEL_W = 11;
	localparam int STEP_W  = 8;
	localparam int WAIT_W  = 7;
	localparam int BRIGHT_W = 10;
	localparam int LVL_W   = 7;
	localparam int INDEX_W = 2;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 11'd1024;

	localparam logic [1:0] MODE_SOLID  = 2'd0;
	localparam logic [1:0] MODE_BREATHE = 2'd1;
	localparam logic [1:0] MODE_FLASH  = 2'd2;
	localparam logic [1:0] MODE_BLINK  = 2'd3;

	localparam logic [INDEX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_RED   = 2'd1;
	localparam logic [INDEX_W-1:0] REG_GREEN = 2'd2;
	localparam logic [INDEX_W-1:0] REG_BLUE  = 2'd3;

	localparam logic [WAIT_W-1:0] WAIT_BREATHE    = 7'd2;
	localparam logic [WAIT_W-1:0] WAIT_FLASH      = 7'd5;
	localparam logic [WAIT_W-1:0] WAIT_FLASH_LONG = 7'd85;
	localparam logic [WAIT_W-1:0] WAIT_HOLD       = 7'd10;

	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	typedef struct packed {
		logic       start;
		logic       dec_wait;
		logic       simple_step;
		logic       square;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       breathe_done;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic wait_zero;
		logic breathe;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/rgbseq_ifs.sv =====
`default_nettype none

interface rgbseq_in_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface rgbseq_out_if;
	logic                          valid;
	logic                          ready;
	logic [rgbseq_pkg::LEVEL_W-1:0] red_duty;
	logic [rgbseq_pkg::LEVEL_W-1:0] green_duty;
	logic [rgbseq_pkg::LEVEL_W-1:0] blue_duty;
	logic                          updated;

	modport source (output valid, output red_duty, output green_duty, output blue_duty,
		output updated, input ready);
	modport sink (input valid, input red_duty, input green_duty, input blue_duty,
		input updated, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_led_pattern_sequencer_unit.sv =====
// channel   direction  payload                                      transaction
// in_ch     sink       tick                                         valid && ready
// out_ch    source     red_duty, green_duty, blue_duty, updated     valid && ready
// cfg       write      cfg_we, cfg_index, cfg_wdata                 cfg_we high
//
// a breathe step loads the result register after the states square, multiply
// red, green, blue and done (one shared multiplier, one colour at a time); every
// other transaction goes straight to done; one transaction at a time, the next
// accepted the cycle after the load; the output register lets the next one be
// accepted while a result still waits downstream
// arst_n clears counters and held duties, sets breathe mode and full red
`default_nettype none

module rgb_led_pattern_sequencer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	rgbseq_in_if.sink                           in_ch,
	rgbseq_out_if.source                        out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [rgbseq_pkg::INDEX_W-1:0] cfg_index,
	input  wire logic [rgbseq_pkg::LEVEL_W-1:0] cfg_wdata
);

	rgbseq_pkg::cmd_t cmd;
	rgbseq_pkg::sts_t sts;

	rgbseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_tick   (in_ch.tick),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	rgbseq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sts        (sts),
		.red_duty   (out_ch.red_duty),
		.green_duty (out_ch.green_duty),
		.blue_duty  (out_ch.blue_duty),
		.updated    (out_ch.updated)
	);

endmodule

`default_nettype wire

// ===== rtl/rgbseq_ctrl.sv =====
`default_nettype none

module rgbseq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_tick,
	output logic                    in_ready,
	input  wire logic               out_ready,
	output logic                    out_valid,
	input  wire rgbseq_pkg::sts_t   sts,
	output rgbseq_pkg::cmd_t        cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SQUARE = 3'd1;
	localparam logic [2:0] S_MUL_R  = 3'd2;
	localparam logic [2:0] S_MUL_G  = 3'd3;
	localparam logic [2:0] S_MUL_B  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = S_DONE;
					if (in_tick) begin
						if (sts.wait_zero) begin
							if (sts.breathe) begin
								state_nxt = S_SQUARE;
							end else begin
								cmd.simple_step = 1'b1;
							end
						end else begin
							cmd.dec_wait = 1'b1;
						end
					end
				end
			end
			S_SQUARE: begin
				cmd.square = 1'b1;
				state_nxt  = S_MUL_R;
			end
			S_MUL_R: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rgbseq_pkg::SEL_RED;
				state_nxt   = S_MUL_G;
			end
			S_MUL_G: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rgbseq_pkg::SEL_GREEN;
				state_nxt   = S_MUL_B;
			end
			S_MUL_B: begin
				cmd.mul_en       = 1'b1;
				cmd.mul_sel      = rgbseq_pkg::SEL_BLUE;
				cmd.breathe_done = 1'b1;
				state_nxt        = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/rgbseq_dp.sv =====
`default_nettype none

module rgbseq_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [rgbseq_pkg::INDEX_W-1:0]     cfg_index,
	input  wire logic [rgbseq_pkg::LEVEL_W-1:0]     cfg_wdata,
	input  wire rgbseq_pkg::cmd_t                   cmd,
	output rgbseq_pkg::sts_t                        sts,
	output logic [rgbseq_pkg::LEVEL_W-1:0]          red_duty,
	output logic [rgbseq_pkg::LEVEL_W-1:0]          green_duty,
	output logic [rgbseq_pkg::LEVEL_W-1:0]          blue_duty,
	output logic                                    updated
);

	logic [1:0]                          mode_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      red_lvl_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      grn_lvl_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      blu_lvl_q;
	logic [rgbseq_pkg::STEP_W-1:0]       step_q;
	logic [rgbseq_pkg::WAIT_W-1:0]       wait_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      held_red_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      held_grn_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      held_blu_q;
	logic [rgbseq_pkg::BRIGHT_W-1:0]     bright_q;
	logic                                upd_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      red_duty_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      grn_duty_q;
	logic [rgbseq_pkg::LEVEL_W-1:0]      blu_duty_q;
	logic                                updated_q;

	logic [rgbseq_pkg::LEVEL_W-1:0]      sat_data;
	logic [rgbseq_pkg::LVL_W-1:0]        tri_lvl;
	logic [2*rgbseq_pkg::LVL_W-1:0]      square;
	logic [rgbseq_pkg::LEVEL_W-1:0]      mul_lvl;
	logic [rgbseq_pkg::BRIGHT_W+rgbseq_pkg::LEVEL_W-1:0] product;
	logic [rgbseq_pkg::LEVEL_W-1:0]      scaled;
	logic                                show_on;
	logic [rgbseq_pkg::WAIT_W-1:0]       simple_wait;
	logic [rgbseq_pkg::STEP_W-1:0]       simple_step_nxt;

	assign sat_data = (cfg_wdata > rgbseq_pkg::FULL_LEVEL) ? rgbseq_pkg::FULL_LEVEL : cfg_wdata;

	// triangle: 255 - s for the upper half is the inverse of the low seven bits
	assign tri_lvl = step_q[7] ? ~step_q[6:0] : step_q[6:0];
	assign square  = tri_lvl * tri_lvl;

	always_comb begin
		case (cmd.mul_sel)
			rgbseq_pkg::SEL_RED:   mul_lvl = red_lvl_q;
			rgbseq_pkg::SEL_GREEN: mul_lvl = grn_lvl_q;
			rgbseq_pkg::SEL_BLUE:  mul_lvl = blu_lvl_q;
			default:               mul_lvl = '0;
		endcase
	end

	assign product = bright_q * mul_lvl;
	assign scaled  = product[rgbseq_pkg::BRIGHT_W+rgbseq_pkg::LEVEL_W-1:rgbseq_pkg::BRIGHT_W];

	always_comb begin
		show_on         = 1'b1;
		simple_wait     = rgbseq_pkg::WAIT_HOLD;
		simple_step_nxt = step_q;
		case (mode_q)
			rgbseq_pkg::MODE_FLASH: begin
				show_on         = (step_q == 8'd0) || (step_q == 8'd2);
				simple_wait     = (step_q == 8'd3) ? rgbseq_pkg::WAIT_FLASH_LONG
				                                   : rgbseq_pkg::WAIT_FLASH;
				simple_step_nxt = {6'd0, step_q[1:0] + 2'd1};
			end
			rgbseq_pkg::MODE_BLINK: begin
				show_on         = (step_q == 8'd0);
				simple_step_nxt = {7'd0, ~step_q[0]};
			end
			default: begin
				show_on = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= rgbseq_pkg::MODE_BREATHE;
			red_lvl_q  <= rgbseq_pkg::FULL_LEVEL;
			grn_lvl_q  <= '0;
			blu_lvl_q  <= '0;
			step_q     <= '0;
			wait_q     <= '0;
			held_red_q <= '0;
			held_grn_q <= '0;
			held_blu_q <= '0;
			upd_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rgbseq_pkg::REG_MODE: begin
						if (cfg_wdata[1:0] != mode_q) begin
							mode_q <= cfg_wdata[1:0];
							step_q <= '0;
							wait_q <= '0;
						end
					end
					rgbseq_pkg::REG_RED:   red_lvl_q <= sat_data;
					rgbseq_pkg::REG_GREEN: grn_lvl_q <= sat_data;
					rgbseq_pkg::REG_BLUE:  blu_lvl_q <= sat_data;
					default: begin
					end
				endcase
			end
			if (cmd.start) begin
				upd_q <= cmd.simple_step;
			end
			if (cmd.square) begin
				upd_q <= 1'b1;
			end
			if (cmd.dec_wait) begin
				wait_q <= wait_q - 7'd1;
			end
			if (cmd.simple_step) begin
				held_red_q <= show_on ? red_lvl_q : '0;
				held_grn_q <= show_on ? grn_lvl_q : '0;
				held_blu_q <= show_on ? blu_lvl_q : '0;
				wait_q     <= simple_wait;
				step_q     <= simple_step_nxt;
			end
			if (cmd.mul_en) begin
				case (cmd.mul_sel)
					rgbseq_pkg::SEL_RED:   held_red_q <= scaled;
					rgbseq_pkg::SEL_GREEN: held_grn_q <= scaled;
					rgbseq_pkg::SEL_BLUE:  held_blu_q <= scaled;
					default: begin
					end
				endcase
			end
			if (cmd.breathe_done) begin
				wait_q <= rgbseq_pkg::WAIT_BREATHE;
				step_q <= step_q + 8'd1;
			end
		end
	end

	// brightness = level squared over 16
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			bright_q <= square[2*rgbseq_pkg::LVL_W-1:4];
		end
		if (cmd.load_out) begin
			red_duty_q <= held_red_q;
			grn_duty_q <= held_grn_q;
			blu_duty_q <= held_blu_q;
			updated_q  <= upd_q;
		end
	end

	assign sts.wait_zero = (wait_q == '0);
	assign sts.breathe   = (mode_q == rgbseq_pkg::MODE_BREATHE);

	assign red_duty   = red_duty_q;
	assign green_duty = grn_duty_q;
	assign blue_duty  = blu_duty_q;
	assign updated    = updated_q;

endmodule

`default_nettype wire
